[rtl/core/ovct_pkg.sv]
// ============================================================================
// ovct_pkg
// Shared types and constants of the overcurrent window trip block.
// ============================================================================
`timescale 1ns / 1ps

package ovct_pkg;

    // Number of over-limit hits that must fall within the window to trip.
    localparam int HIT_COUNT = 4;
    localparam int HEAD_W    = (HIT_COUNT > 1) ? $clog2(HIT_COUNT) : 1;
    localparam int FILL_W    = $clog2(HIT_COUNT + 1);

    localparam int SAMPLE_W  = 12;
    localparam int MA_W      = 16;
    localparam int TIME_W    = 32;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;

    // Product of a 12-bit delta and a 16-bit scale.
    localparam int PROD_W    = SAMPLE_W + MA_W;
    localparam int DIV_CNT_W = $clog2(PROD_W + 1);

    localparam logic [SAMPLE_W-1:0] SAT_LEVEL = SAMPLE_W'(4090);
    localparam logic [MA_W-1:0]     MA_MAX    = 16'hFFFF;
    localparam logic [MA_W-1:0]     CNT_MAX   = 16'hFFFF;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_OFFSET   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PROTECT_EN    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL      = 3'd5;

    typedef struct packed {
        logic [SAMPLE_W-1:0] zero_offset;
        logic [MA_W-1:0]     full_scale_ma;
        logic [MA_W-1:0]     trip_threshold_ma;
        logic                protect_enable;
        logic [MA_W-1:0]     window_ms;
        logic [MA_W-1:0]     sample_interval_ms;
    } cfg_t;

    typedef struct packed {
        logic clear;
        logic push;
    } ring_ctl_t;

endpackage

[rtl/core/ovct_cfg.sv]
// ============================================================================
// ovct_cfg
// Configuration register file, written one register per beat.
// ============================================================================
`timescale 1ns / 1ps

module ovct_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr_en,
    input  logic [ovct_pkg::CFG_IDX_W-1:0] wr_index,
    input  logic [ovct_pkg::CFG_W-1:0]     wr_data,
    output ovct_pkg::cfg_t                 cfg
);
    import ovct_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                REG_ZERO_OFFSET: cfg_next.zero_offset        = wr_data[SAMPLE_W-1:0];
                REG_FULL_SCALE:  cfg_next.full_scale_ma      = wr_data;
                REG_THRESHOLD:   cfg_next.trip_threshold_ma  = wr_data;
                REG_PROTECT_EN:  cfg_next.protect_enable     = wr_data[0];
                REG_WINDOW:      cfg_next.window_ms          = wr_data;
                REG_INTERVAL:    cfg_next.sample_interval_ms = wr_data;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.zero_offset        <= SAMPLE_W'(2048);
            cfg_reg.full_scale_ma      <= MA_W'(20000);
            cfg_reg.trip_threshold_ma  <= '0;
            cfg_reg.protect_enable     <= 1'b0;
            cfg_reg.window_ms          <= MA_W'(100);
            cfg_reg.sample_interval_ms <= MA_W'(1);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[rtl/core/ovct_div.sv]
// ============================================================================
// ovct_div
// Serial restoring divider, one quotient bit per cycle.
// ============================================================================
`timescale 1ns / 1ps

module ovct_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [ovct_pkg::PROD_W-1:0]   dividend,
    input  logic [ovct_pkg::SAMPLE_W-1:0] divisor,
    output logic                         done,
    output logic [ovct_pkg::PROD_W-1:0]   quotient
);
    import ovct_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [PROD_W-1:0]    quo_reg, quo_next;
    logic [SAMPLE_W-1:0]  rem_reg, rem_next;
    logic [SAMPLE_W-1:0]  dvs_reg, dvs_next;
    logic [SAMPLE_W:0]    rem_shift;
    logic [SAMPLE_W:0]    rem_diff;
    logic                 q_bit;

    // The dividend shifts out of the top of quo_reg while quotient bits enter
    // at the bottom.
    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[PROD_W-1]};
        rem_diff  = rem_shift - {1'b0, dvs_reg};
        q_bit     = (rem_shift >= {1'b0, dvs_reg});

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;

        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(PROD_W);
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[PROD_W-2:0], q_bit};
            rem_next = q_bit ? rem_diff[SAMPLE_W-1:0] : rem_shift[SAMPLE_W-1:0];
            cnt_next = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[rtl/core/ovct_ring.sv]
// ============================================================================
// ovct_ring
// Ring of over-limit hit timestamps with a full-window check.
// ============================================================================
`timescale 1ns / 1ps

module ovct_ring (
    input  logic                       clk,
    input  logic                       rst_n,
    input  ovct_pkg::ring_ctl_t        ctl,
    input  logic [ovct_pkg::TIME_W-1:0] now_ms,
    input  logic [ovct_pkg::MA_W-1:0]   window_ms,
    output logic                       in_window
);
    import ovct_pkg::*;

    logic [TIME_W-1:0] hit_times_reg [HIT_COUNT];
    logic [HEAD_W-1:0] head_reg, head_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [TIME_W-1:0] age;
    logic              full;

    always_comb
    begin
        head_next = head_reg;
        fill_next = fill_reg;
        if (ctl.clear)
        begin
            head_next = '0;
            fill_next = '0;
        end
        else if (ctl.push)
        begin
            head_next = (head_reg == HEAD_W'(HIT_COUNT - 1)) ? '0 : head_reg + HEAD_W'(1);
            if (fill_reg != FILL_W'(HIT_COUNT))
            begin
                fill_next = fill_reg + FILL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            head_reg <= head_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.push && !ctl.clear)
        begin
            hit_times_reg[head_reg] <= now_ms;
        end
    end

    // After a push the head points at the oldest stored hit.
    assign full      = (fill_reg == FILL_W'(HIT_COUNT));
    assign age       = now_ms - hit_times_reg[head_reg];
    assign in_window = full && (age <= {{(TIME_W-MA_W){1'b0}}, window_ms});

endmodule

[rtl/core/overcurrent_window_trip_top.sv]
// ============================================================================
// overcurrent_window_trip_top
// Overcurrent protector with a sliding window of over-limit hits.
// ============================================================================
// Usage:
// Each input beat (in_valid/in_stall) carries a sensor sample, a millisecond
// timestamp and a fault-clear request, and yields exactly one result beat
// (out_valid/out_stall). An input closer than sample_interval_ms to the last
// accepted sample is ignored and goes straight to the finish state.
// An accepted sample steps through the multiply, divide, check and finish
// states in turn; it is scaled to mA by a serial divider that produces one
// quotient bit per cycle. One item is processed at a time: in_stall is high
// from acceptance until the result is loaded into the output register, so
// no new input is taken before the last one is through. A new input can be
// taken while that result still waits under out_stall; a finished result
// waits for a free output register.
// Configuration writes (cfg_valid/cfg_ready) are always taken and must only
// be issued while no item is in flight.
// Reset loads the register defaults, empties the hit ring, clears the fault
// and the trip count, and drops out_valid. No clearing pass is needed.
// ============================================================================
`timescale 1ns / 1ps

module overcurrent_window_trip_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ovct_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ovct_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [ovct_pkg::SAMPLE_W-1:0]  sample,
    input  logic [ovct_pkg::TIME_W-1:0]    now_ms,
    input  logic                          fault_clear,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          sampled,
    output logic [ovct_pkg::MA_W-1:0]      current_ma,
    output logic                          saturated,
    output logic                          fault,
    output logic                          trip,
    output logic [ovct_pkg::MA_W-1:0]      trip_count
);
    import ovct_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_MUL    = 3'd1;
    localparam logic [2:0] ST_DIV    = 3'd2;
    localparam logic [2:0] ST_CHECK  = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    cfg_t       cfg;
    ring_ctl_t  ring_ctl;
    logic       ring_in_window;
    logic       div_start;
    logic       div_done;
    logic [PROD_W-1:0] div_quotient;
    logic [PROD_W-1:0] product;
    logic [SAMPLE_W-1:0] delta;
    logic [PROD_W-1:0] ma;
    logic [TIME_W-1:0] since_last;
    logic       in_fire;
    logic       out_free;

    logic [2:0]          state_reg, state_next;
    logic [SAMPLE_W-1:0] smp_reg, smp_next;
    logic [TIME_W-1:0]   now_reg, now_next;
    logic [TIME_W-1:0]   last_time_reg, last_time_next;
    logic [MA_W-1:0]     held_cur_reg, held_cur_next;
    logic                held_sat_reg, held_sat_next;
    logic                fault_reg, fault_next;
    logic [MA_W-1:0]     trip_cnt_reg, trip_cnt_next;
    logic                sampled_reg, sampled_next;
    logic                trip_reg, trip_next;
    logic                pushed_reg, pushed_next;

    logic                out_valid_reg, out_valid_next;
    logic                out_sampled_reg, out_sampled_next;
    logic [MA_W-1:0]     out_cur_reg, out_cur_next;
    logic                out_sat_reg, out_sat_next;
    logic                out_fault_reg, out_fault_next;
    logic                out_trip_reg, out_trip_next;
    logic [MA_W-1:0]     out_cnt_reg, out_cnt_next;

    assign cfg_ready = 1'b1;

    ovct_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    ovct_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (product),
        .divisor  (cfg.zero_offset),
        .done     (div_done),
        .quotient (div_quotient)
    );

    ovct_ring u_ring (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ring_ctl),
        .now_ms    (now_reg),
        .window_ms (cfg.window_ms),
        .in_window (ring_in_window)
    );

    assign in_stall   = (state_reg != ST_IDLE);
    assign in_fire    = in_valid && !in_stall;
    assign out_free   = !out_valid_reg || !out_stall;
    assign since_last = now_ms - last_time_reg;

    // Readings at or below zero, or a zero offset of zero, give no current.
    assign delta = (cfg.zero_offset != '0 && smp_reg > cfg.zero_offset)
                   ? smp_reg - cfg.zero_offset : '0;
    assign product = PROD_W'(delta) * PROD_W'(cfg.full_scale_ma);
    assign ma      = (cfg.zero_offset == '0) ? '0 : div_quotient;

    always_comb
    begin
        state_next     = state_reg;
        smp_next       = smp_reg;
        now_next       = now_reg;
        last_time_next = last_time_reg;
        held_cur_next  = held_cur_reg;
        held_sat_next  = held_sat_reg;
        fault_next     = fault_reg;
        trip_cnt_next  = trip_cnt_reg;
        sampled_next   = sampled_reg;
        trip_next      = trip_reg;
        pushed_next    = pushed_reg;
        div_start      = 1'b0;
        ring_ctl       = '0;

        out_valid_next   = out_valid_reg && out_stall;
        out_sampled_next = out_sampled_reg;
        out_cur_next     = out_cur_reg;
        out_sat_next     = out_sat_reg;
        out_fault_next   = out_fault_reg;
        out_trip_next    = out_trip_reg;
        out_cnt_next     = out_cnt_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    smp_next   = sample;
                    now_next   = now_ms;
                    trip_next  = 1'b0;
                    fault_next = fault_reg && !fault_clear;
                    if (since_last >= {{(TIME_W-MA_W){1'b0}}, cfg.sample_interval_ms})
                    begin
                        sampled_next   = 1'b1;
                        last_time_next = now_ms;
                        state_next     = ST_MUL;
                    end
                    else
                    begin
                        sampled_next = 1'b0;
                        state_next   = ST_FINISH;
                    end
                end
            end
            ST_MUL:
            begin
                held_sat_next = (smp_reg >= SAT_LEVEL);
                div_start     = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    held_cur_next = (ma > PROD_W'(MA_MAX)) ? MA_MAX : ma[MA_W-1:0];
                    pushed_next   = 1'b0;
                    if (fault_reg || !cfg.protect_enable)
                    begin
                        ring_ctl.clear = 1'b1;
                    end
                    else if (ma > PROD_W'(cfg.trip_threshold_ma))
                    begin
                        ring_ctl.push = 1'b1;
                        pushed_next   = 1'b1;
                    end
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (pushed_reg && ring_in_window)
                begin
                    trip_next      = 1'b1;
                    fault_next     = 1'b1;
                    ring_ctl.clear = 1'b1;
                    if (trip_cnt_reg != CNT_MAX)
                    begin
                        trip_cnt_next = trip_cnt_reg + MA_W'(1);
                    end
                end
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_sampled_next = sampled_reg;
                    out_cur_next     = held_cur_reg;
                    out_sat_next     = held_sat_reg;
                    out_fault_next   = fault_reg;
                    out_trip_next    = trip_reg;
                    out_cnt_next     = trip_cnt_reg;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            last_time_reg <= '0;
            held_cur_reg  <= '0;
            held_sat_reg  <= 1'b0;
            fault_reg     <= 1'b0;
            trip_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            last_time_reg <= last_time_next;
            held_cur_reg  <= held_cur_next;
            held_sat_reg  <= held_sat_next;
            fault_reg     <= fault_next;
            trip_cnt_reg  <= trip_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        smp_reg         <= smp_next;
        now_reg         <= now_next;
        sampled_reg     <= sampled_next;
        trip_reg        <= trip_next;
        pushed_reg      <= pushed_next;
        out_sampled_reg <= out_sampled_next;
        out_cur_reg     <= out_cur_next;
        out_sat_reg     <= out_sat_next;
        out_fault_reg   <= out_fault_next;
        out_trip_reg    <= out_trip_next;
        out_cnt_reg     <= out_cnt_next;
    end

    assign out_valid  = out_valid_reg;
    assign sampled    = out_sampled_reg;
    assign current_ma = out_cur_reg;
    assign saturated  = out_sat_reg;
    assign fault      = out_fault_reg;
    assign trip       = out_trip_reg;
    assign trip_count = out_cnt_reg;

    // A reported trip always comes from an accepted sample and latches the fault.
    a_trip_has_fault: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && trip) |-> (fault && sampled))
        else $error("trip reported without a latched fault on an accepted sample");

    // The trip counter only ever steps up by one.
    a_count_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (trip_cnt_reg != $past(trip_cnt_reg)) |-> (trip_cnt_reg == $past(trip_cnt_reg) + MA_W'(1)))
        else $error("trip counter changed by other than one");

    // The divider is never restarted while a result is being computed.
    a_div_single: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && !div_done) |=> !div_start)
        else $error("divider restarted during a division");

endmodule

[tb/overcurrent_window_trip_top_test.sv]
`timescale 1ns / 1ps
// ============================================================================
// overcurrent_window_trip_top_test
// Self-checking testbench for the overcurrent window trip block. A behavioral
// predictor tracks scaling, the sample interval filter, the hit ring and the
// fault latch, and every result beat is compared field by field against it.
// Directed cases cover scaling extremes, trips and timestamp wrap. Random
// bursts under varying settings, idle gaps and back-pressure follow.
// ============================================================================

module overcurrent_window_trip_top_test;
    import ovct_pkg::*;

    localparam int CLK_HALF           = 5;
    localparam int RESET_CYCLES       = 5;
    localparam int DRAIN_SETTLE       = 40;
    localparam int CYCLE_LIMIT        = 1_000_000;
    localparam int LONG_HOLD          = 400;
    localparam int CONFIGS_PER_MODE   = 4;
    localparam int SAMPLES_PER_CONFIG = 100;
    localparam int MAX_PRINTED        = 25;

    typedef struct {
        logic            sampled;
        logic [MA_W-1:0] current_ma;
        logic            saturated;
        logic            fault;
        logic            trip;
        logic [MA_W-1:0] trip_count;
    } protector_result_t;

    logic                 clk         = 1'b0;
    logic                 rst_n       = 1'b0;
    logic                 cfg_valid   = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index   = '0;
    logic [CFG_W-1:0]     cfg_data    = '0;
    logic                 in_valid    = 1'b0;
    logic                 in_stall;
    logic [SAMPLE_W-1:0]  sample      = '0;
    logic [TIME_W-1:0]    now_ms      = '0;
    logic                 fault_clear = 1'b0;
    logic                 out_valid;
    logic                 out_stall   = 1'b0;
    logic                 sampled;
    logic [MA_W-1:0]      current_ma;
    logic                 saturated;
    logic                 fault;
    logic                 trip;
    logic [MA_W-1:0]      trip_count;

    // Predictor state.
    cfg_t              model_cfg;
    logic [TIME_W-1:0] hit_stamps [HIT_COUNT];
    int                ring_wr;
    int                ring_used;
    logic              fault_held;
    logic [MA_W-1:0]   trips_total;
    logic [TIME_W-1:0] last_taken;
    logic [MA_W-1:0]   held_ma;
    logic              held_sat;

    protector_result_t pending_results [$];

    int send_idle_pct    = 0;
    int recv_idle_pct    = 0;
    int hold_request     = 0;
    int hold_left        = 0;
    int cycle_count      = 0;
    int error_count      = 0;
    int results_checked  = 0;
    int readings_sent    = 0;
    int samples_taken    = 0;
    int trips_predicted  = 0;
    int settings_applied = 0;

    overcurrent_window_trip_top i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .sample      (sample),
        .now_ms      (now_ms),
        .fault_clear (fault_clear),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .sampled     (sampled),
        .current_ma  (current_ma),
        .saturated   (saturated),
        .fault       (fault),
        .trip        (trip),
        .trip_count  (trip_count)
    );

    always #CLK_HALF clk = ~clk;

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles", cycle_count);
        $display("overcurrent_window_trip_top_test NOT OK");
        $finish;
    end

    function automatic void reset_model();
        model_cfg.zero_offset        = 12'd2048;
        model_cfg.full_scale_ma      = 16'd20000;
        model_cfg.trip_threshold_ma  = 16'd0;
        model_cfg.protect_enable     = 1'b0;
        model_cfg.window_ms          = 16'd100;
        model_cfg.sample_interval_ms = 16'd1;
        ring_wr     = 0;
        ring_used   = 0;
        fault_held  = 1'b0;
        trips_total = '0;
        last_taken  = '0;
        held_ma     = '0;
        held_sat    = 1'b0;
    endfunction

    // Advances the predictor by one accepted input beat.
    function automatic protector_result_t evaluate_reading(input logic [SAMPLE_W-1:0] smp,
                                                           input logic [TIME_W-1:0] now,
                                                           input logic clr);
        protector_result_t r;
        logic [TIME_W-1:0] elapsed;
        logic [TIME_W-1:0] span;
        logic [TIME_W-1:0] delta;
        logic [TIME_W-1:0] ma;
        r.sampled = 1'b0;
        r.trip    = 1'b0;
        if (clr)
            fault_held = 1'b0;
        elapsed = now - last_taken;
        if (elapsed >= TIME_W'(model_cfg.sample_interval_ms))
        begin
            r.sampled  = 1'b1;
            last_taken = now;
            held_sat   = (smp >= SAT_LEVEL);
            ma = '0;
            if (model_cfg.zero_offset != 0 && smp > model_cfg.zero_offset)
            begin
                delta = TIME_W'(smp) - TIME_W'(model_cfg.zero_offset);
                ma = (delta * TIME_W'(model_cfg.full_scale_ma)) /
                     TIME_W'(model_cfg.zero_offset);
            end
            held_ma = (ma > TIME_W'(MA_MAX)) ? MA_MAX : ma[MA_W-1:0];
            if (fault_held || !model_cfg.protect_enable)
            begin
                ring_wr   = 0;
                ring_used = 0;
            end
            else if (ma > TIME_W'(model_cfg.trip_threshold_ma))
            begin
                hit_stamps[ring_wr] = now;
                ring_wr = (ring_wr + 1) % HIT_COUNT;
                if (ring_used < HIT_COUNT)
                    ring_used++;
                if (ring_used == HIT_COUNT)
                begin
                    // The slot after the newest hit holds the oldest one.
                    span = now - hit_stamps[ring_wr];
                    if (span <= TIME_W'(model_cfg.window_ms))
                    begin
                        r.trip     = 1'b1;
                        fault_held = 1'b1;
                        if (trips_total != CNT_MAX)
                            trips_total++;
                        ring_wr   = 0;
                        ring_used = 0;
                    end
                end
            end
        end
        r.current_ma = held_ma;
        r.saturated  = held_sat;
        r.fault      = fault_held;
        r.trip_count = trips_total;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        error_count++;
        if (error_count <= MAX_PRINTED)
            $display("[%0t] mismatch on %s at result %0d: got %0d, expected %0d",
                     $time, what, results_checked, got, want);
    endtask

    always @(posedge clk)
    begin : result_check
        protector_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected result beat", 1, 0);
            else
            begin
                want = pending_results.pop_front();
                results_checked++;
                if (sampled !== want.sampled)
                    report_mismatch("sampled", sampled, want.sampled);
                if (current_ma !== want.current_ma)
                    report_mismatch("current_ma", current_ma, want.current_ma);
                if (saturated !== want.saturated)
                    report_mismatch("saturated", saturated, want.saturated);
                if (fault !== want.fault)
                    report_mismatch("fault", fault, want.fault);
                if (trip !== want.trip)
                    report_mismatch("trip", trip, want.trip);
                if (trip_count !== want.trip_count)
                    report_mismatch("trip_count", trip_count, want.trip_count);
            end
        end
    end

    // Result side: random stalls, or a long hold-off when one is requested.
    always @(posedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else
            out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    task automatic send_reading(input logic [SAMPLE_W-1:0] smp, input logic [TIME_W-1:0] now,
                                input logic clr);
        protector_result_t r;
        while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        sample      <= smp;
        now_ms      <= now;
        fault_clear <= clr;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        r = evaluate_reading(smp, now, clr);
        pending_results.push_back(r);
        readings_sent++;
        if (r.sampled)
            samples_taken++;
        if (r.trip)
            trips_predicted++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_ZERO_OFFSET: model_cfg.zero_offset        = data[SAMPLE_W-1:0];
            REG_FULL_SCALE:  model_cfg.full_scale_ma      = data[MA_W-1:0];
            REG_THRESHOLD:   model_cfg.trip_threshold_ma  = data[MA_W-1:0];
            REG_PROTECT_EN:  model_cfg.protect_enable     = data[0];
            REG_WINDOW:      model_cfg.window_ms          = data[MA_W-1:0];
            REG_INTERVAL:    model_cfg.sample_interval_ms = data[MA_W-1:0];
            default: ;
        endcase
    endtask

    // Only called with nothing in flight.
    task automatic apply_settings(input cfg_t c);
        write_reg(REG_ZERO_OFFSET, CFG_W'(c.zero_offset));
        write_reg(REG_FULL_SCALE, c.full_scale_ma);
        write_reg(REG_THRESHOLD, c.trip_threshold_ma);
        write_reg(REG_PROTECT_EN, CFG_W'(c.protect_enable));
        write_reg(REG_WINDOW, c.window_ms);
        write_reg(REG_INTERVAL, c.sample_interval_ms);
        cfg_valid <= 1'b0;
        settings_applied++;
    endtask

    function automatic cfg_t make_settings(input logic [SAMPLE_W-1:0] zero,
                                           input logic [MA_W-1:0] full,
                                           input logic [MA_W-1:0] thr, input logic en,
                                           input logic [MA_W-1:0] win,
                                           input logic [MA_W-1:0] intv);
        cfg_t c;
        c.zero_offset        = zero;
        c.full_scale_ma      = full;
        c.trip_threshold_ma  = thr;
        c.protect_enable     = en;
        c.window_ms          = win;
        c.sample_interval_ms = intv;
        return c;
    endfunction

    function automatic cfg_t draw_settings();
        cfg_t c;
        case ($urandom_range(0, 11))
            0:       c.zero_offset = '0;
            1:       c.zero_offset = 12'd1;
            2:       c.zero_offset = 12'hFFF;
            default: c.zero_offset = SAMPLE_W'($urandom_range(1024, 3072));
        endcase
        if ($urandom_range(0, 9) == 0)
            c.full_scale_ma = $urandom_range(0, 1) ? MA_MAX : '0;
        else
            c.full_scale_ma = MA_W'($urandom_range(1000, 40000));
        if ($urandom_range(0, 9) == 0)
            c.trip_threshold_ma = $urandom_range(0, 1) ? MA_MAX : '0;
        else
            c.trip_threshold_ma = MA_W'($urandom_range(0, c.full_scale_ma));
        c.protect_enable = ($urandom_range(0, 99) < 80);
        if ($urandom_range(0, 9) == 0)
            c.window_ms = $urandom_range(0, 1) ? 16'hFFFF : 16'h0;
        else
            c.window_ms = MA_W'($urandom_range(10, 300));
        if ($urandom_range(0, 9) == 0)
            c.sample_interval_ms = $urandom_range(0, 1) ? 16'hFFFF : 16'h0;
        else
            c.sample_interval_ms = MA_W'($urandom_range(0, 20));
        return c;
    endfunction

    // Lowest raw reading whose current clears the threshold, roughly.
    function automatic int hot_floor();
        longint unsigned zero;
        longint unsigned full;
        longint unsigned lvl;
        zero = model_cfg.zero_offset;
        full = model_cfg.full_scale_ma;
        if (zero == 0 || full == 0)
            return 0;
        lvl = zero + (longint'(model_cfg.trip_threshold_ma) * zero) / full + 1;
        return (lvl > 4095) ? 4095 : int'(lvl);
    endfunction

    function automatic logic [TIME_W-1:0] draw_timestamp();
        int r;
        int unsigned intv;
        r    = $urandom_range(0, 99);
        intv = model_cfg.sample_interval_ms;
        if (r < 4)
            return $urandom;
        if (r < 18 && intv != 0)
            return last_taken + $urandom_range(0, intv - 1);
        return last_taken + intv + $urandom_range(0, model_cfg.window_ms / 3 + 3);
    endfunction

    // Bursts of hot or mixed readings, spaced so that hits tend to land in
    // the window; occasionally the sender pauses until the block is empty.
    task automatic run_random_config(input int n_samples);
        int start;
        int burst_len;
        int floor_lvl;
        bit hot;
        logic [SAMPLE_W-1:0] smp;
        logic clr;
        start     = samples_taken;
        floor_lvl = hot_floor();
        while (samples_taken - start < n_samples)
        begin
            burst_len = $urandom_range(2, 8);
            hot = ($urandom_range(0, 99) < 65);
            for (int i = 0; i < burst_len; i++)
            begin
                case ($urandom_range(0, 19))
                    0: smp = 12'd0;
                    1: smp = 12'd4089;
                    2: smp = SAT_LEVEL;
                    3: smp = 12'hFFF;
                    default: smp = hot ? SAMPLE_W'($urandom_range(floor_lvl, 4095)) :
                                         SAMPLE_W'($urandom_range(0, 4095));
                endcase
                clr = (i == 0) ? ($urandom_range(0, 1) == 1) : ($urandom_range(0, 99) < 8);
                send_reading(smp, draw_timestamp(), clr);
            end
            if ($urandom_range(0, 9) == 0)
                wait_drained();
        end
    endtask

    task automatic test_scaling_and_ignore();
        // Reset defaults: the first beat at time zero is too early.
        send_reading(12'd2048, 32'd0, 1'b0);
        send_reading(12'd4095, 32'd1, 1'b0);
        send_reading(SAT_LEVEL, 32'd2, 1'b1);
        send_reading(12'd4089, 32'd3, 1'b0);
        send_reading(12'd0, 32'd4, 1'b0);
        send_reading(12'd2048, 32'd5, 1'b0);
        wait_drained();
        apply_settings(make_settings(12'd0, 16'd20000, 16'd0, 1'b0, 16'd100, 16'd1));
        send_reading(12'hFFF, 32'd10, 1'b0);
        wait_drained();
        apply_settings(make_settings(12'hFFF, 16'hFFFF, 16'd0, 1'b0, 16'd100, 16'hFFFF));
        send_reading(12'hFFF, 32'd65545, 1'b0);
        send_reading(12'd4094, 32'd131079, 1'b0);
        wait_drained();
    endtask

    task automatic test_trip_window();
        // Zero of one makes the product overflow the output range.
        apply_settings(make_settings(12'd1, 16'hFFFF, 16'hFFFF, 1'b1, 16'd0, 16'd0));
        repeat (5) send_reading(12'hFFF, 32'd200000, 1'b0);
        send_reading(12'hFFF, 32'd200001, 1'b1);
        wait_drained();
        apply_settings(make_settings(12'd2048, 16'd20000, 16'd100, 1'b1, 16'd100, 16'd10));
        send_reading(12'd3000, 32'd300000, 1'b1);
        send_reading(12'd3000, 32'd300005, 1'b1);
        send_reading(12'd3000, 32'd300040, 1'b0);
        send_reading(12'd3000, 32'd300080, 1'b0);
        send_reading(12'd3000, 32'd300120, 1'b0);
        send_reading(12'd3000, 32'd300160, 1'b0);
    endtask

    task automatic test_timestamp_wrap();
        // The last of these trips across the wrap of the millisecond counter.
        send_reading(12'd3000, 32'hFFFF_FFD0, 1'b0);
        send_reading(12'd3000, 32'hFFFF_FFF0, 1'b0);
        send_reading(12'd3000, 32'h0000_0010, 1'b0);
        send_reading(12'd3000, 32'h0000_0030, 1'b0);
        wait_drained();
    endtask

    task automatic test_backpressure();
        apply_settings(make_settings(12'd2048, 16'd20000, 16'd500, 1'b1, 16'd100, 16'd1));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request  = LONG_HOLD;
        repeat (10) send_reading(SAMPLE_W'($urandom_range(2500, 4095)), draw_timestamp(),
                                 ($urandom_range(0, 3) == 0));
        wait_drained();
    endtask

    task automatic test_random_traffic();
        for (int mode = 0; mode < 3; mode++)
        begin
            case (mode)
                0:
                begin
                    send_idle_pct = 36;
                    recv_idle_pct = 55;
                end
                1:
                begin
                    send_idle_pct = 55;
                    recv_idle_pct = 36;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int k = 0; k < CONFIGS_PER_MODE; k++)
            begin
                wait_drained();
                apply_settings(draw_settings());
                run_random_config(SAMPLES_PER_CONFIG);
            end
        end
    endtask

    initial
    begin
        reset_model();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_scaling_and_ignore();
        test_trip_window();
        test_timestamp_wrap();
        test_backpressure();
        test_random_traffic();

        wait_drained();
        if (pending_results.size() != 0)
            report_mismatch("results never delivered", 0, pending_results.size());
        $display("Ran %0d readings: %0d taken as samples, %0d too early, %0d trips.",
                 readings_sent, samples_taken, readings_sent - samples_taken,
                 trips_predicted);
        $display("%0d register settings, idle gaps on both sides, a long output hold-off.",
                 settings_applied);
        if (error_count == 0)
            $display("overcurrent_window_trip_top_test OK");
        else
            $display("overcurrent_window_trip_top_test NOT OK");
        $finish;
    end

endmodule
